>>> hw/rtl/lcfr_pkg.sv
// ----------------------------------------------------------------------------
// lcfr_pkg
// shared types and constants of the length/checksum frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package lcfr_pkg;

	localparam logic [7:0] HDR_FIRST     = 8'hAA;
	localparam logic [7:0] HDR_SECOND    = 8'hAF;
	localparam logic [7:0] FUNC_LIMIT    = 8'hF1;
	localparam logic [7:0] MAX_LEN_RESET = 8'd49;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_HDR1 = 3'd1,
		PH_HDR2 = 3'd2,
		PH_FUNC = 3'd3,
		PH_DATA = 3'd4,
		PH_CSUM = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_GOOD    = 2'd1,
		KIND_BAD     = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic [7:0] func_code;
		logic [7:0] payload_len;
		logic       last;
	} res_t;

endpackage

`default_nettype wire

>>> hw/rtl/lcfr_stream_if.sv
// ----------------------------------------------------------------------------
// lcfr_stream_if
// valid/ready channels for received bytes and for frame results
// ----------------------------------------------------------------------------
`default_nettype none

interface lcfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lcfr_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [7:0] func_code;
	logic [7:0] payload_len;
	logic       last;

	modport source (output valid, output kind, output data_byte, output func_code,
		output payload_len, output last, input ready);
	modport sink   (input valid, input kind, input data_byte, input func_code,
		input payload_len, input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lcfr_parser.sv
// ----------------------------------------------------------------------------
// lcfr_parser
// frame state machine with running checksum, one byte per step
// ----------------------------------------------------------------------------
`default_nettype none

module lcfr_parser
	import lcfr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] rx_byte,
	input  wire logic [7:0] max_len,
	output      logic       emit,
	output      res_t       res
);

	phase_t     phase_q, phase_d;
	logic [7:0] remaining_q, remaining_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] func_q, func_d;
	logic [7:0] len_q, len_d;
	logic       in_data;

	assign in_data = (phase_q == PH_DATA) && (remaining_q != 8'd0);

	// next state
	always_comb begin
		phase_d     = PH_IDLE;
		remaining_d = remaining_q;
		sum_d       = sum_q;
		func_d      = func_q;
		len_d       = len_q;
		priority if (phase_q == PH_IDLE && rx_byte == HDR_FIRST) begin
			phase_d = PH_HDR1;
			sum_d   = rx_byte;
		end else if (phase_q == PH_HDR1 && rx_byte == HDR_SECOND) begin
			phase_d = PH_HDR2;
			sum_d   = sum_q + rx_byte;
		end else if (phase_q == PH_HDR2 && rx_byte < FUNC_LIMIT) begin
			phase_d = PH_FUNC;
			func_d  = rx_byte;
			sum_d   = sum_q + rx_byte;
		end else if (phase_q == PH_FUNC && rx_byte <= max_len) begin
			phase_d     = PH_DATA;
			len_d       = rx_byte;
			remaining_d = rx_byte;
			sum_d       = sum_q + rx_byte;
		end else if (in_data) begin
			remaining_d = remaining_q - 8'd1;
			sum_d       = sum_q + rx_byte;
			phase_d     = (remaining_q == 8'd1) ? PH_CSUM : PH_DATA;
		end else begin
			// checksum byte, mismatch, zero length or unused code: back to idle
			phase_d = PH_IDLE;
		end
	end

	// outputs
	always_comb begin
		emit            = 1'b0;
		res.kind        = KIND_PAYLOAD;
		res.data_byte   = rx_byte;
		res.func_code   = func_q;
		res.payload_len = len_q;
		res.last        = 1'b0;
		unique case (phase_q)
			PH_DATA: begin
				emit = in_data;
			end
			PH_CSUM: begin
				emit     = 1'b1;
				res.kind = (sum_q == rx_byte) ? KIND_GOOD : KIND_BAD;
				res.last = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			remaining_q <= 8'd0;
			sum_q       <= 8'd0;
			func_q      <= 8'd0;
			len_q       <= 8'd0;
		end else if (step) begin
			phase_q     <= phase_d;
			remaining_q <= remaining_d;
			sum_q       <= sum_d;
			func_q      <= func_d;
			len_q       <= len_d;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/lcfr_out_stage.sv
// ----------------------------------------------------------------------------
// lcfr_out_stage
// result register driving the result channel
// ----------------------------------------------------------------------------
`default_nettype none

module lcfr_out_stage
	import lcfr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     load,
	input  wire res_t     res_in,
	output      logic     busy,
	lcfr_result_if.source res
);

	logic valid_s2;
	res_t res_s2;

	assign busy = valid_s2 && !res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res_in;
		end
	end

	assign res.valid       = valid_s2;
	assign res.kind        = res_s2.kind;
	assign res.data_byte   = res_s2.data_byte;
	assign res.func_code   = res_s2.func_code;
	assign res.payload_len = res_s2.payload_len;
	assign res.last        = res_s2.last;

endmodule

`default_nettype wire

>>> hw/rtl/length_checksum_frame_receiver.sv
// ----------------------------------------------------------------------------
// length_checksum_frame_receiver
// finds header/function/length/payload/checksum frames in a byte stream
// ----------------------------------------------------------------------------
// usage:
//   rx carries one received byte per beat; res carries one result per beat:
//   each payload byte as it arrives (kind payload, last low), then a verdict
//   on the checksum byte (kind good or bad, last high, data_byte = checksum).
//   header, function, length bytes and bytes that break a frame give no beat.
//   cfg_wr_en / cfg_wr_data write the largest accepted length byte; write it
//   only while no beat is in flight.
// timing:
//   a byte is taken into the input register, parsed there by the single parse
//   step, and its result lands in the result register. one byte per cycle
//   sustained while res is not held off.
// stalls:
//   while res is held off, the input register still advances bytes that make
//   no result; a byte that makes a result waits, and rx.ready drops once the
//   input register is full and cannot move.
// reset:
//   arst_n clears the frame state to idle, drops both valid flags and loads
//   the length limit with 49.
// ----------------------------------------------------------------------------
`default_nettype none

module length_checksum_frame_receiver
	import lcfr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data,
	lcfr_byte_if.sink       rx,
	lcfr_result_if.source   res
);

	// length limit register
	logic [7:0] max_len_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// parse step handshake
	logic       emit;
	logic       busy;
	logic       step;
	res_t       res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	// a byte moves on unless it makes a result and the result register is stuck
	assign step     = valid_s1 && !(emit && busy);
	assign rx.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	lcfr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.max_len (max_len_q),
		.emit    (emit),
		.res     (res_d)
	);

	lcfr_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step && emit),
		.res_in (res_d),
		.busy   (busy),
		.res    (res)
	);

	// checks

	// verdict beats and only those are marked last
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.last == (res.kind != KIND_PAYLOAD)))
		else $error("last does not match result kind");

	// a parsed result never lands on an undelivered one
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(step && emit) |-> (!res.valid || res.ready))
		else $error("result register overwritten");

	// a held input byte is not lost
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !step) |=> (valid_s1 && $stable(byte_s1)))
		else $error("input register lost a byte");

	// limit register follows the write port
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> (max_len_q == $past(cfg_wr_data)))
		else $error("length limit not written");

endmodule

`default_nettype wire
